// ----- sv/twq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the timer work queue.
package twq_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned IdBitsDef   = 16;
  localparam int unsigned TimeBitsDef = 32;
  localparam int unsigned QDepth      = 2;

  localparam logic [15:0] ClientInvalid = 16'hFFFF;

  typedef enum logic [2:0] {
    FN_SCHED  = 3'd0,
    FN_UPDATE = 3'd1,
    FN_CAN_ID = 3'd2,
    FN_CAN_CL = 3'd3,
    FN_TICK   = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_ALLOWED = 3'd1,
    ST_INVALID     = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_FULL        = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    K_SCHED,
    K_UPDATE,
    K_CAN_ID,
    K_CAN_CL,
    K_TICK,
    K_REJECT
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    status_e     rej_status;
    logic        rej_sched;
    logic [15:0] work_id;
    logic [15:0] client;
    logic [31:0] start;
    logic [31:0] period;
    logic [31:0] now;
    logic        rearm;
  } op_t;

endpackage

// ----- sv/timer_work_queue.sv -----
`timescale 1ns / 1ps
// Sequence from acceptance to result valid: queue step, two table scans, apply step,
// output step; refused operations take one scan and then the output step.
// The back end takes a new operation only after the result has left the output step;
// each scan reads one table entry per cycle, and a held result stalls the output step.
// The two-deep queue lets the front accept while the back end works.
// Reset: asynchronous, active low; clears valid bits, time, enable and queue, ids to all ones.
module timer_work_queue import twq_pkg::*; #(
  parameter int unsigned CAPACITY  = CapacityDef,
  parameter int unsigned ID_BITS   = IdBitsDef,
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [15:0] work_id_i,
  input  logic [15:0] client_i,
  input  logic        has_work_i,
  input  logic [31:0] start_i,
  input  logic [31:0] period_i,
  input  logic [31:0] now_i,
  input  logic        rearm_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] result_id_o,
  output logic        fired_o,
  output logic [15:0] fired_client_o,
  output logic [31:0] nearest_time_o,
  output logic        empty_res_o
);

  op_t  op_in, op_out;
  logic full, empty, pop;

  assign in_stall_o = full;

  twq_front u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .func_i, .work_id_i, .client_i, .has_work_i, .start_i,
    .period_i, .now_i, .rearm_i, .op_o(op_in)
  );

  twq_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(in_valid_i && !full), .data_i(op_in),
    .full_o(full), .pop_i(pop), .empty_o(empty), .data_o(op_out)
  );

  twq_back #(
    .CAPACITY(CAPACITY), .ID_BITS(ID_BITS), .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .op_i(op_out), .pop_o(pop),
    .out_valid_o, .out_stall_i, .status_o, .result_id_o, .fired_o,
    .fired_client_o, .nearest_time_o, .empty_res_o
  );

endmodule

// ----- sv/twq_front.sv -----
`timescale 1ns / 1ps
// Front end: holds the enable register and classifies incoming operations.
module twq_front import twq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic [2:0]  func_i,
  input  logic [15:0] work_id_i,
  input  logic [15:0] client_i,
  input  logic        has_work_i,
  input  logic [31:0] start_i,
  input  logic [31:0] period_i,
  input  logic [31:0] now_i,
  input  logic        rearm_i,
  output op_t         op_o
);

  logic enabled_q, enabled_d;

  assign cfg_ready_o = 1'b1;
  assign enabled_d   = cfg_valid_i ? cfg_data_i : enabled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
    end else begin
      enabled_q <= enabled_d;
    end
  end

  always_comb begin
    op_o            = '0;
    op_o.work_id    = work_id_i;
    op_o.client     = client_i;
    op_o.start      = start_i;
    op_o.period     = period_i;
    op_o.now        = now_i;
    op_o.rearm      = rearm_i;
    op_o.rej_status = ST_OK;
    op_o.rej_sched  = (func_i == FN_SCHED);
    unique case (func_i)
      FN_SCHED:  op_o.kind = K_SCHED;
      FN_UPDATE: op_o.kind = K_UPDATE;
      FN_CAN_ID: op_o.kind = K_CAN_ID;
      FN_CAN_CL: op_o.kind = K_CAN_CL;
      FN_TICK:   op_o.kind = K_TICK;
      default: begin
        op_o.kind       = K_REJECT;
        op_o.rej_status = ST_INVALID;
      end
    endcase
    if (op_o.kind != K_REJECT) begin
      // argument checks take priority over the enable
      if ((func_i inside {FN_SCHED, FN_UPDATE}) &&
          (client_i == ClientInvalid || !has_work_i)) begin
        op_o.kind       = K_REJECT;
        op_o.rej_status = ST_INVALID;
      end else if (!enabled_q) begin
        op_o.kind       = K_REJECT;
        op_o.rej_status = ST_NOT_ALLOWED;
      end
    end
  end

endmodule

// ----- sv/twq_fifo.sv -----
`timescale 1ns / 1ps
// Short operation queue between front and back end.
module twq_fifo import twq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output op_t  data_o
);

  localparam int unsigned PW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned NW = $clog2(QDepth + 1);

  op_t            mem_q [QDepth];
  logic [PW-1:0]  wp_q, rp_q;
  logic [NW-1:0]  cnt_q;

  assign full_o  = (cnt_q == NW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(QDepth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == PW'(QDepth - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + NW'(push_i) - NW'(pop_i);
    end
  end

endmodule

// ----- sv/twq_back.sv -----
`timescale 1ns / 1ps
// Back end: entry table, scan sequencer and result register.
module twq_back import twq_pkg::*; #(
  parameter int unsigned CAPACITY  = CapacityDef,
  parameter int unsigned ID_BITS   = IdBitsDef,
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  op_t         op_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] result_id_o,
  output logic        fired_o,
  output logic [15:0] fired_client_o,
  output logic [31:0] nearest_time_o,
  output logic        empty_res_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (ID_BITS > 16) ? ID_BITS : 16;
  localparam int unsigned TW = (TIME_BITS > 32) ? TIME_BITS : 32;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_OUT} state_e;

  logic [ID_BITS-1:0]   id_mem  [CAPACITY];
  logic [15:0]          cl_mem  [CAPACITY];
  logic [TIME_BITS-1:0] due_mem [CAPACITY];
  logic [TIME_BITS-1:0] per_mem [CAPACITY];

  logic [ID_BITS-1:0]   rd_id;
  logic [15:0]          rd_cl;
  logic [TIME_BITS-1:0] rd_due, rd_per;

  state_e               state_q;
  op_t                  op_q;
  logic                 near_q;
  logic [CW-1:0]        cnt_q;
  logic                 iss_q;
  logic [AW-1:0]        iss_idx_q;
  logic [CAPACITY-1:0]  valid_q;
  logic [ID_BITS-1:0]   next_id_q;
  logic [TIME_BITS-1:0] cur_time_q;

  logic                 free_fnd_q, hit_fnd_q, any_cl_q, best_fnd_q;
  logic [AW-1:0]        free_slot_q, hit_slot_q, best_slot_q;
  logic [ID_BITS-1:0]   best_id_q;
  logic [15:0]          best_cl_q;
  logic [TIME_BITS-1:0] best_due_q, best_per_q;

  status_e              st_q;
  logic [ID_BITS-1:0]   rid_q;
  logic                 fired_q;
  logic [15:0]          fcl_q;

  logic                 out_valid_q;
  logic [2:0]           status_out_q;
  logic [15:0]          rid_out_q, fcl_out_q;
  logic                 fired_out_q, empty_out_q;
  logic [31:0]          near_out_q;

  // masked views of the operation fields
  logic [IW-1:0]        wid_ext;
  logic [ID_BITS-1:0]   wid_k;
  logic [TW-1:0]        start_ext, per_ext, now_ext;
  logic [TIME_BITS-1:0] start_k, per_k, now_k;

  assign wid_ext   = IW'(op_q.work_id);
  assign wid_k     = wid_ext[ID_BITS-1:0];
  assign start_ext = TW'(op_q.start);
  assign per_ext   = TW'(op_q.period);
  assign now_ext   = TW'(op_q.now);
  assign start_k   = start_ext[TIME_BITS-1:0];
  assign per_k     = per_ext[TIME_BITS-1:0];
  assign now_k     = now_ext[TIME_BITS-1:0];

  // table read, registered
  logic [AW-1:0] rd_addr;
  assign rd_addr = cnt_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    rd_id  <= id_mem[rd_addr];
    rd_cl  <= cl_mem[rd_addr];
    rd_due <= due_mem[rd_addr];
    rd_per <= per_mem[rd_addr];
  end

  // write port, used in the apply step
  logic                 we_id, we_cl, we_due, we_per;
  logic [AW-1:0]        wr_addr;
  logic [TIME_BITS-1:0] wr_due;
  logic [ID_BITS-1:0]   nid_inc, nid;

  assign nid_inc = next_id_q + 1'b1;
  assign nid     = (&nid_inc) ? nid_inc + 1'b1 : nid_inc;

  always_comb begin
    we_id   = 1'b0;
    we_cl   = 1'b0;
    we_due  = 1'b0;
    we_per  = 1'b0;
    wr_addr = free_slot_q;
    wr_due  = start_k;
    if (state_q == S_APPLY) begin
      case (op_q.kind)
        K_SCHED: begin
          we_id  = free_fnd_q;
          we_cl  = free_fnd_q;
          we_due = free_fnd_q;
          we_per = free_fnd_q;
          wr_due = (start_k == '0) ? cur_time_q : start_k;
        end
        K_UPDATE: begin
          wr_addr = hit_slot_q;
          we_cl   = hit_fnd_q;
          we_due  = hit_fnd_q;
          we_per  = hit_fnd_q;
        end
        K_TICK: begin
          wr_addr = best_slot_q;
          we_due  = best_fnd_q && op_q.rearm && (best_per_q != '0);
          wr_due  = best_due_q + best_per_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_id)  id_mem[wr_addr]  <= nid;
    if (we_cl)  cl_mem[wr_addr]  <= op_q.client;
    if (we_due) due_mem[wr_addr] <= wr_due;
    if (we_per) per_mem[wr_addr] <= per_k;
  end

  // candidate evaluation for the entry coming out of the table
  logic rd_vld, cand_ok, cand_better;
  assign rd_vld      = iss_q && valid_q[iss_idx_q];
  assign cand_ok     = rd_vld && (near_q || (op_q.kind == K_TICK && rd_due <= now_k));
  assign cand_better = !best_fnd_q || (rd_due < best_due_q) ||
                       (rd_due == best_due_q && rd_id < best_id_q);

  assign pop_o = (state_q == S_IDLE) && !empty_i;

  logic [IW-1:0] rid_ext;
  logic [TW-1:0] near_ext;
  assign rid_ext  = IW'(rid_q);
  assign near_ext = TW'(best_due_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      near_q      <= 1'b0;
      cnt_q       <= '0;
      iss_q       <= 1'b0;
      iss_idx_q   <= '0;
      valid_q     <= '0;
      next_id_q   <= '1;
      cur_time_q  <= '0;
      free_fnd_q  <= 1'b0;
      hit_fnd_q   <= 1'b0;
      any_cl_q    <= 1'b0;
      best_fnd_q  <= 1'b0;
      free_slot_q <= '0;
      hit_slot_q  <= '0;
      best_slot_q <= '0;
      best_id_q   <= '0;
      best_cl_q   <= '0;
      best_due_q  <= '0;
      best_per_q  <= '0;
      st_q        <= ST_OK;
      rid_q       <= '0;
      fired_q     <= 1'b0;
      fcl_q       <= '0;
      out_valid_q <= 1'b0;
      status_out_q <= '0;
      rid_out_q   <= '0;
      fcl_out_q   <= '0;
      fired_out_q <= 1'b0;
      empty_out_q <= 1'b1;
      near_out_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            op_q       <= op_i;
            near_q     <= (op_i.kind == K_REJECT);
            cnt_q      <= '0;
            iss_q      <= 1'b0;
            free_fnd_q <= 1'b0;
            hit_fnd_q  <= 1'b0;
            any_cl_q   <= 1'b0;
            best_fnd_q <= 1'b0;
            st_q       <= op_i.rej_status;
            rid_q      <= (op_i.kind == K_REJECT && op_i.rej_sched) ? '1 : '0;
            fired_q    <= 1'b0;
            fcl_q      <= '0;
            state_q    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one read a cycle, evaluate it the cycle after
          if (cnt_q < CW'(CAPACITY)) begin
            iss_q     <= 1'b1;
            iss_idx_q <= cnt_q[AW-1:0];
            cnt_q     <= cnt_q + 1'b1;
          end else begin
            iss_q <= 1'b0;
          end
          if (iss_q) begin
            if (!near_q) begin
              if (!valid_q[iss_idx_q] && !free_fnd_q) begin
                free_fnd_q  <= 1'b1;
                free_slot_q <= iss_idx_q;
              end
              if (rd_vld && rd_id == wid_k && !hit_fnd_q) begin
                hit_fnd_q  <= 1'b1;
                hit_slot_q <= iss_idx_q;
              end
              if (op_q.kind == K_CAN_CL && rd_vld && rd_cl == op_q.client) begin
                valid_q[iss_idx_q] <= 1'b0;
                any_cl_q           <= 1'b1;
              end
            end
            if (cand_ok && cand_better) begin
              best_fnd_q  <= 1'b1;
              best_slot_q <= iss_idx_q;
              best_id_q   <= rd_id;
              best_cl_q   <= rd_cl;
              best_due_q  <= rd_due;
              best_per_q  <= rd_per;
            end
          end else if (cnt_q == CW'(CAPACITY)) begin
            state_q <= near_q ? S_OUT : S_APPLY;
          end
        end
        S_APPLY: begin
          case (op_q.kind)
            K_SCHED: begin
              if (free_fnd_q) begin
                next_id_q            <= nid;
                valid_q[free_slot_q] <= 1'b1;
                rid_q                <= nid;
              end else begin
                st_q  <= ST_FULL;
                rid_q <= '1;
              end
            end
            K_UPDATE: if (!hit_fnd_q) st_q <= ST_NOT_FOUND;
            K_CAN_ID: begin
              if (hit_fnd_q) valid_q[hit_slot_q] <= 1'b0;
              else st_q <= ST_NOT_FOUND;
            end
            K_CAN_CL: if (!any_cl_q) st_q <= ST_NOT_FOUND;
            K_TICK: begin
              cur_time_q <= now_k;
              if (best_fnd_q) begin
                fired_q <= 1'b1;
                rid_q   <= best_id_q;
                fcl_q   <= best_cl_q;
                if (!(op_q.rearm && best_per_q != '0)) valid_q[best_slot_q] <= 1'b0;
              end
            end
            default: ;
          endcase
          // second pass for the nearest due time after the change
          near_q     <= 1'b1;
          cnt_q      <= '0;
          iss_q      <= 1'b0;
          best_fnd_q <= 1'b0;
          state_q    <= S_SCAN;
        end
        S_OUT: begin
          if (!out_valid_q) begin
            out_valid_q  <= 1'b1;
            status_out_q <= st_q;
            rid_out_q    <= rid_ext[15:0];
            fired_out_q  <= fired_q;
            fcl_out_q    <= fcl_q;
            near_out_q   <= best_fnd_q ? near_ext[31:0] : '0;
            empty_out_q  <= !best_fnd_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_out_q;
  assign result_id_o    = rid_out_q;
  assign fired_o        = fired_out_q;
  assign fired_client_o = fcl_out_q;
  assign nearest_time_o = near_out_q;
  assign empty_res_o    = empty_out_q;

endmodule

// ----- sv/twq_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the timer work queue, bound to the top level.
module twq_checker import twq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic        fired_o,
  input logic [31:0] nearest_time_o,
  input logic        empty_res_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_empty_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_res_o |-> nearest_time_o == '0)
    else $error("empty queue reports a nearest time");

  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fired_o |-> status_o == ST_OK)
    else $error("fired with failing status");

  a_fire_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> !fired_o)
    else $error("refused operation fired an entry");

endmodule

bind timer_work_queue twq_checker u_twq_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .status_o, .fired_o,
  .nearest_time_o, .empty_res_o
);
